/* rtl/lmt3_pkg.sv */
// ----------------------------------------------------------------------------
// lmt3_pkg
// Shared types and constants of the 3x3 thresholded local-maximum block:
// register map, configuration record and per-item pipeline tag.
// ----------------------------------------------------------------------------
`default_nettype none

package lmt3_pkg;

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int IW_W     = 11;
    localparam int IH_W     = 13;
    localparam int THR_W    = 32;
    localparam int OCOL_W   = 10;
    localparam int OROW_W   = 12;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [IW_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [IH_W-1:0]  HEIGHT_RESET = 13'd1024;
    localparam logic [THR_W-1:0] THR_RESET    = 32'd1;

    localparam logic [IH_W-1:0]  MIN_HEIGHT   = 13'd3;
    localparam logic [IH_W-1:0]  MAX_HEIGHT   = 13'd4096;

    typedef struct packed {
        logic [IW_W-1:0]         image_width;
        logic [IH_W-1:0]         image_height;
        logic signed [THR_W-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic              emit;
        logic              last;
        logic              par;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/lmt3_regs.sv */
// ----------------------------------------------------------------------------
// lmt3_regs
// APB register file: image width, image height and peak threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt3_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lmt3_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lmt3_pkg::PDATA_W-1:0]  pwdata,
    output logic      [lmt3_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output lmt3_pkg::cfg_t                     cfg
);

    lmt3_pkg::cfg_t cfg_reg;
    lmt3_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                lmt3_pkg::REG_IMAGE_WIDTH: begin
                    cfg_next.image_width = pwdata[lmt3_pkg::IW_W-1:0];
                end
                lmt3_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_next.image_height = pwdata[lmt3_pkg::IH_W-1:0];
                end
                lmt3_pkg::REG_THRESHOLD: begin
                    cfg_next.threshold = pwdata[lmt3_pkg::THR_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= lmt3_pkg::WIDTH_RESET;
            cfg_reg.image_height <= lmt3_pkg::HEIGHT_RESET;
            cfg_reg.threshold    <= lmt3_pkg::THR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            lmt3_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            lmt3_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            lmt3_pkg::REG_THRESHOLD:    prdata = 32'(cfg_reg.threshold);
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/lmt3_line_mem.sv */
// ----------------------------------------------------------------------------
// lmt3_line_mem
// Single line buffer: one write and one registered read per cycle,
// read-before-write on the same address.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt3_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
        if (wr_en) begin
            mem[addr] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* rtl/lmt3_judge.sv */
// ----------------------------------------------------------------------------
// lmt3_judge
// Window stage: takes line-buffer read data, shifts the 3x3 window, tests
// the centre against its eight neighbors and the threshold, and holds the
// result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt3_judge #(
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire lmt3_pkg::tag_t                        in_tag,
    input  wire logic signed [PIXEL_BITS-1:0]          in_pixel,
    input  wire logic        [PIXEL_BITS-1:0]          q0,
    input  wire logic        [PIXEL_BITS-1:0]          q1,
    input  wire logic signed [lmt3_pkg::THR_W-1:0]     threshold,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_is_peak,
    output logic             [lmt3_pkg::OCOL_W-1:0]    m_centre_col,
    output logic             [lmt3_pkg::OROW_W-1:0]    m_centre_row,
    output logic                                       m_frame_last
);

    localparam int CMP_W = (PIXEL_BITS > lmt3_pkg::THR_W) ? PIXEL_BITS : lmt3_pkg::THR_W;

    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    lmt3_pkg::tag_t                  tag_reg;
    logic signed [PIXEL_BITS-1:0]    bot_reg;
    logic signed [PIXEL_BITS-1:0]    win_reg [6];

    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic                            peak_reg;
    logic [lmt3_pkg::OCOL_W-1:0]     col_reg;
    logic [lmt3_pkg::OROW_W-1:0]     row_reg;
    logic                            last_reg;

    logic signed [PIXEL_BITS-1:0]    top;
    logic signed [PIXEL_BITS-1:0]    mid;
    logic signed [PIXEL_BITS-1:0]    ctr;
    logic signed [CMP_W-1:0]         ctr_x;
    logic signed [CMP_W-1:0]         thr_x;
    logic                            peak;
    logic                            out_free;
    logic                            s1_go;
    logic                            emit_go;

    assign top = tag_reg.par ? $signed(q1) : $signed(q0);
    assign mid = tag_reg.par ? $signed(q0) : $signed(q1);
    assign ctr = win_reg[4];

    assign ctr_x = CMP_W'(ctr);
    assign thr_x = CMP_W'(threshold);

    assign peak = (ctr_x > thr_x) &&
                  (ctr > win_reg[0]) && (ctr > win_reg[1]) && (ctr > win_reg[2]) &&
                  (ctr > win_reg[3]) && (ctr > win_reg[5]) &&
                  (ctr > top) && (ctr > mid) && (ctr > bot_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign s1_go    = s1_valid_reg && (!tag_reg.emit || out_free);
    assign emit_go  = s1_go && tag_reg.emit;
    assign in_ready = !s1_valid_reg || s1_go;

    always_comb begin
        if (in_valid && in_ready) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb begin
        if (emit_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            tag_reg <= in_tag;
            bot_reg <= in_pixel;
        end
        if (s1_go) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot_reg;
        end
        if (emit_go) begin
            peak_reg <= peak;
            col_reg  <= tag_reg.col;
            row_reg  <= tag_reg.row;
            last_reg <= tag_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_peak    = peak_reg;
    assign m_centre_col = col_reg;
    assign m_centre_row = row_reg;
    assign m_frame_last = last_reg;

endmodule

`default_nettype wire

/* rtl/local_max_threshold_3x3_top.sv */
// ----------------------------------------------------------------------------
// local_max_threshold_3x3_top
// Thresholded 3x3 non-maximum suppression on a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes signed pixels in raster order and, for every interior pixel, returns
// one item that marks whether it strictly exceeds the threshold and all eight
// neighbors; border pixels give no item. Throughput is one pixel per cycle
// while the output is free, set by the single read and write port of each of
// the two line memories (one per row parity, MAX_WIDTH entries each); an item
// passes the window stage and output registers after its completing pixel is
// accepted. The line memories are not cleared: the first two rows of a frame
// fill them. Change the size or threshold only while the block is idle.
`default_nettype none

module local_max_threshold_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lmt3_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [lmt3_pkg::PDATA_W-1:0]      pwdata,
    output logic      [lmt3_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [PIXEL_BITS-1:0]      s_pixel_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_is_peak,
    output logic      [lmt3_pkg::OCOL_W-1:0]       m_centre_col,
    output logic      [lmt3_pkg::OROW_W-1:0]       m_centre_row,
    output logic                                   m_frame_last
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WC_RAW = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W = (WC_RAW > lmt3_pkg::IW_W) ? WC_RAW : lmt3_pkg::IW_W;
    localparam int IH_W   = lmt3_pkg::IH_W;
    localparam int ROW_W  = lmt3_pkg::OROW_W;

    lmt3_pkg::cfg_t         cfg;
    lmt3_pkg::tag_t         tag;

    logic [COL_W-1:0]       col_reg;
    logic [COL_W-1:0]       col_next;
    logic [ROW_W-1:0]       row_reg;
    logic [ROW_W-1:0]       row_next;

    logic [WCMP_W-1:0]      w_raw;
    logic [WCMP_W-1:0]      eff_w;
    logic [IH_W-1:0]        eff_h;
    logic                   wrap_pre;
    logic [COL_W-1:0]       c0;
    logic [IH_W-1:0]        r0_inc;
    logic [ROW_W-1:0]       r0;
    logic [WCMP_W-1:0]      c_inc;
    logic [IH_W-1:0]        r_inc;
    logic [WCMP_W-1:0]      c_m1;
    logic [ROW_W-1:0]       r_m1;
    logic                   s_acc;
    logic                   par;
    logic [PIXEL_BITS-1:0]  q0;
    logic [PIXEL_BITS-1:0]  q1;

    lmt3_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        w_raw = WCMP_W'(cfg.image_width);
        if (w_raw < WCMP_W'(3)) begin
            eff_w = WCMP_W'(3);
        end else if (w_raw > WCMP_W'(MAX_WIDTH)) begin
            eff_w = WCMP_W'(MAX_WIDTH);
        end else begin
            eff_w = w_raw;
        end
        if (cfg.image_height < lmt3_pkg::MIN_HEIGHT) begin
            eff_h = lmt3_pkg::MIN_HEIGHT;
        end else if (cfg.image_height > lmt3_pkg::MAX_HEIGHT) begin
            eff_h = lmt3_pkg::MAX_HEIGHT;
        end else begin
            eff_h = cfg.image_height;
        end
    end

    // position of the incoming pixel, folded into the current frame size
    always_comb begin
        wrap_pre = WCMP_W'(col_reg) >= eff_w;
        c0       = wrap_pre ? '0 : col_reg;
        r0_inc   = wrap_pre ? (IH_W'(row_reg) + IH_W'(1)) : IH_W'(row_reg);
        r0       = (r0_inc >= eff_h) ? '0 : r0_inc[ROW_W-1:0];
        par      = r0[0];
    end

    always_comb begin
        c_inc = WCMP_W'(c0) + WCMP_W'(1);
        r_inc = IH_W'(r0) + IH_W'(1);
        if (c_inc >= eff_w) begin
            col_next = '0;
            row_next = (r_inc >= eff_h) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r0;
        end
    end

    always_comb begin
        c_m1     = WCMP_W'(c0) - WCMP_W'(1);
        r_m1     = r0 - ROW_W'(1);
        tag.emit = (c0 >= COL_W'(2)) && (r0 >= ROW_W'(2));
        tag.last = (WCMP_W'(c0) == (eff_w - WCMP_W'(1))) &&
                   (IH_W'(r0) == (eff_h - IH_W'(1)));
        tag.par  = par;
        tag.col  = c_m1[lmt3_pkg::OCOL_W-1:0];
        tag.row  = r_m1;
    end

    assign s_acc = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    lmt3_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_BITS),
        .ADDR_W (COL_W)
    ) u_line_even (
        .aclk  (aclk),
        .rd_en (s_acc),
        .wr_en (s_acc && !par),
        .addr  (c0),
        .wdata (s_pixel_value),
        .rdata (q0)
    );

    lmt3_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_BITS),
        .ADDR_W (COL_W)
    ) u_line_odd (
        .aclk  (aclk),
        .rd_en (s_acc),
        .wr_en (s_acc && par),
        .addr  (c0),
        .wdata (s_pixel_value),
        .rdata (q1)
    );

    lmt3_judge #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_judge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_tag       (tag),
        .in_pixel     (s_pixel_value),
        .q0           (q0),
        .q1           (q1),
        .threshold    (cfg.threshold),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_peak    (m_is_peak),
        .m_centre_col (m_centre_col),
        .m_centre_row (m_centre_row),
        .m_frame_last (m_frame_last)
    );

endmodule

`default_nettype wire
